// File: rtl/core/dtp_pkg.sv
// Shared constants, types and the fraction weight table of the date and time text parser.
`timescale 1ns / 1ps

package dtp_pkg;

  localparam int CP_W   = 21;
  localparam int YEAR_W = 14;
  localparam int TWO_W  = 7;
  localparam int FRAC_W = 32;
  localparam int POS_W  = 4;

  // Fraction digits that still carry weight; later digits are accepted but add nothing.
  localparam int FRAC_DIGITS = 9;
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SAT   = POS_W'(10);

  localparam logic [YEAR_W-1:0] YEAR_THOUSAND = YEAR_W'(1000);
  localparam logic [YEAR_W-1:0] YEAR_HUNDRED  = YEAR_W'(100);
  localparam logic [YEAR_W-1:0] YEAR_TEN      = YEAR_W'(10);
  localparam logic [TWO_W-1:0]  TWO_TEN       = TWO_W'(10);

  localparam logic [CP_W-1:0] CH_EOT    = CP_W'('h04);
  localparam logic [CP_W-1:0] CH_TAB    = CP_W'('h09);
  localparam logic [CP_W-1:0] CH_LF     = CP_W'('h0A);
  localparam logic [CP_W-1:0] CH_CR     = CP_W'('h0D);
  localparam logic [CP_W-1:0] CH_SPACE  = CP_W'('h20);
  localparam logic [CP_W-1:0] CH_HYPHEN = CP_W'('h2D);
  localparam logic [CP_W-1:0] CH_DOT    = CP_W'('h2E);
  localparam logic [CP_W-1:0] CH_ZERO   = CP_W'('h30);
  localparam logic [CP_W-1:0] CH_NINE   = CP_W'('h39);
  localparam logic [CP_W-1:0] CH_COLON  = CP_W'('h3A);

  // Control from the parser to the fraction accumulator.
  typedef struct packed {
    logic             step;   // an item is being processed this cycle
    logic             last;   // that item ends the string
    logic             add;    // that item is a fraction digit
    logic [3:0]       digit;
  } dtp_frac_ctrl_t;

  // Parsed fields as they stand after the item in flight.
  typedef struct packed {
    logic              ok;
    logic [YEAR_W-1:0] year;
    logic [TWO_W-1:0]  month;
    logic [TWO_W-1:0]  day;
    logic [TWO_W-1:0]  hour;
    logic [TWO_W-1:0]  minute;
    logic [TWO_W-1:0]  second;
  } dtp_fields_t;

  // Weight of fraction digit k+1 in UQ32, that is 10^-(k+1).
  function automatic logic [FRAC_W-1:0] dtp_tenth_pow(input logic [POS_W-1:0] k);
    logic [FRAC_W-1:0] w;
    case (k)
      POS_W'(0): w = 32'h19999999;
      POS_W'(1): w = 32'h028f5c28;
      POS_W'(2): w = 32'h00418937;
      POS_W'(3): w = 32'h00068db8;
      POS_W'(4): w = 32'h0000a7c5;
      POS_W'(5): w = 32'h000010c6;
      POS_W'(6): w = 32'h000001ad;
      POS_W'(7): w = 32'h0000002a;
      POS_W'(8): w = 32'h00000004;
      default:   w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/dtp_parser.sv
// Character state machine with the date and time field accumulators.
`timescale 1ns / 1ps

module dtp_parser
  import dtp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             last,
  input  logic [CP_W-1:0]  code_point,
  output dtp_fields_t      fields,
  output dtp_frac_ctrl_t   frac_ctrl
);

  typedef enum logic [4:0] {
    ST_INIT, ST_Y1, ST_Y2, ST_Y3, ST_YH, ST_M0, ST_M1, ST_MH, ST_D0, ST_D1, ST_DT,
    ST_H1, ST_HC, ST_N0, ST_N1, ST_NC, ST_S0, ST_S1, ST_SEC, ST_FRAC, ST_TIME, ST_ERR
  } state_t;

  state_t            state_r, state_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [TWO_W-1:0]  month_r, month_nxt;
  logic [TWO_W-1:0]  day_r, day_nxt;
  logic [TWO_W-1:0]  hour_r, hour_nxt;
  logic [TWO_W-1:0]  minute_r, minute_nxt;
  logic [TWO_W-1:0]  second_r, second_nxt;

  logic              is_dig;
  logic              is_ws;
  logic              is_eot;
  logic [3:0]        dig;
  logic [YEAR_W-1:0] dig_y;
  logic [TWO_W-1:0]  dig_t;
  logic              frac_add;
  logic [CP_W-1:0]   dig_full;

  assign is_dig   = (code_point >= CH_ZERO) && (code_point <= CH_NINE);
  assign is_ws    = (code_point == CH_TAB) || (code_point == CH_SPACE) ||
                    (code_point == CH_LF) || (code_point == CH_CR);
  assign is_eot   = (code_point == CH_EOT);
  assign dig_full = code_point - CH_ZERO;
  assign dig      = is_dig ? dig_full[3:0] : 4'd0;
  assign dig_y    = YEAR_W'(dig);
  assign dig_t    = TWO_W'(dig);

  always_comb begin
    state_nxt  = ST_ERR;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    frac_add   = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        if (is_ws) begin
          state_nxt = ST_INIT;
        end else if (is_dig) begin
          year_nxt  = year_r + dig_y * YEAR_THOUSAND;
          state_nxt = ST_Y1;
        end
      end
      ST_Y1: if (is_dig) begin
        year_nxt  = year_r + dig_y * YEAR_HUNDRED;
        state_nxt = ST_Y2;
      end
      ST_Y2: if (is_dig) begin
        year_nxt  = year_r + dig_y * YEAR_TEN;
        state_nxt = ST_Y3;
      end
      ST_Y3: if (is_dig) begin
        year_nxt  = year_r + dig_y;
        state_nxt = ST_YH;
      end
      ST_YH: if (code_point == CH_HYPHEN) state_nxt = ST_M0;
      ST_M0: if (is_dig) begin
        month_nxt = month_r + dig_t * TWO_TEN;
        state_nxt = ST_M1;
      end
      ST_M1: if (is_dig) begin
        month_nxt = month_r + dig_t;
        state_nxt = ST_MH;
      end
      ST_MH: if (code_point == CH_HYPHEN) state_nxt = ST_D0;
      ST_D0: if (is_dig) begin
        day_nxt   = day_r + dig_t * TWO_TEN;
        state_nxt = ST_D1;
      end
      ST_D1: if (is_dig) begin
        day_nxt   = day_r + dig_t;
        state_nxt = ST_DT;
      end
      ST_DT: begin
        if (is_ws) begin
          state_nxt = ST_DT;
        end else if (is_dig) begin
          hour_nxt  = hour_r + dig_t * TWO_TEN;
          state_nxt = ST_H1;
        end
      end
      ST_H1: if (is_dig) begin
        hour_nxt  = hour_r + dig_t;
        state_nxt = ST_HC;
      end
      ST_HC: if (code_point == CH_COLON) state_nxt = ST_N0;
      ST_N0: if (is_dig) begin
        minute_nxt = minute_r + dig_t * TWO_TEN;
        state_nxt  = ST_N1;
      end
      ST_N1: if (is_dig) begin
        minute_nxt = minute_r + dig_t;
        state_nxt  = ST_NC;
      end
      ST_NC: if (code_point == CH_COLON) state_nxt = ST_S0;
      ST_S0: if (is_dig) begin
        second_nxt = second_r + dig_t * TWO_TEN;
        state_nxt  = ST_S1;
      end
      ST_S1: if (is_dig) begin
        second_nxt = second_r + dig_t;
        state_nxt  = ST_SEC;
      end
      ST_SEC: begin
        if (code_point == CH_DOT) begin
          state_nxt = ST_FRAC;
        end else if (is_eot || is_ws) begin
          state_nxt = ST_TIME;
        end
      end
      ST_FRAC: begin
        if (is_dig) begin
          frac_add  = 1'b1;
          state_nxt = ST_FRAC;
        end else if (is_ws) begin
          state_nxt = ST_TIME;
        end
      end
      ST_TIME: if (is_eot || is_ws) state_nxt = ST_TIME;
      ST_ERR:  state_nxt = ST_ERR;
      default: state_nxt = ST_ERR;
    endcase
  end

  // The string's last transfer returns everything to the reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
    end else if (step) begin
      if (last) begin
        state_r  <= ST_INIT;
        year_r   <= '0;
        month_r  <= '0;
        day_r    <= '0;
        hour_r   <= '0;
        minute_r <= '0;
        second_r <= '0;
      end else begin
        state_r  <= state_nxt;
        year_r   <= year_nxt;
        month_r  <= month_nxt;
        day_r    <= day_nxt;
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
        second_r <= second_nxt;
      end
    end
  end

  assign fields.ok     = (state_nxt == ST_SEC) || (state_nxt == ST_TIME);
  assign fields.year   = year_nxt;
  assign fields.month  = month_nxt;
  assign fields.day    = day_nxt;
  assign fields.hour   = hour_nxt;
  assign fields.minute = minute_nxt;
  assign fields.second = second_nxt;

  assign frac_ctrl.step  = step;
  assign frac_ctrl.last  = last;
  assign frac_ctrl.add   = frac_add;
  assign frac_ctrl.digit = dig;

endmodule

// File: rtl/core/dtp_frac_acc.sv
// Fraction accumulator: adds digit times 10^-k in UQ32 for the first fraction digits.
`timescale 1ns / 1ps

module dtp_frac_acc
  import dtp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dtp_frac_ctrl_t    ctrl,
  output logic [FRAC_W-1:0] frac_nxt
);

  logic [FRAC_W-1:0] acc_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [FRAC_W-1:0] weight;
  logic [FRAC_W+3:0] term;
  logic              weighted;

  assign weighted = ctrl.add && (pos_r <= POS_W'(FRAC_DIGITS));
  assign weight   = dtp_tenth_pow(pos_r - POS_FIRST);
  assign term     = (FRAC_W + 4)'(ctrl.digit) * (FRAC_W + 4)'(weight);
  assign frac_nxt = weighted ? acc_r + term[FRAC_W-1:0] : acc_r;
  assign pos_nxt  = (ctrl.add && (pos_r < POS_SAT)) ? pos_r + POS_FIRST : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= POS_FIRST;
    end else if (ctrl.step) begin
      if (ctrl.last) begin
        acc_r <= '0;
        pos_r <= POS_FIRST;
      end else begin
        acc_r <= frac_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

// File: rtl/core/datetime_text_parser.sv
// A code point enters the input register and is parsed from there, and the result of a
// string's last code point is captured in the output register.
// Throughput: one code point per cycle unless the output stalls; one parse step each.
// Output back-pressure stalls both stages together through one shared advance signal.
// Synchronous active-low reset empties both stages and puts the parser in its leading
// whitespace state with all fields and the fraction cleared.
`timescale 1ns / 1ps

module datetime_text_parser
  import dtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] code_point, [23:21] zero
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [13:0] year, [20:14] month, [27:21] day, [34:28] hour,
                                  // [41:35] minute, [48:42] second, [80:49] fraction,
                                  // [87:81] zero
  output logic [0:0]  out_tuser   // [0] valid_res
);

  logic              s1_valid_r;
  logic [CP_W-1:0]   s1_cp_r;
  logic              s1_last_r;
  logic              advance;
  logic              step;
  logic              out_valid_r;
  logic [87:0]       out_data_r;
  logic              out_ok_r;
  dtp_fields_t       fields;
  dtp_frac_ctrl_t    frac_ctrl;
  logic [FRAC_W-1:0] frac_nxt;
  logic [87:0]       res_data;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign step      = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cp_r   <= in_tdata[CP_W-1:0];
      s1_last_r <= in_tlast;
    end
  end

  dtp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .last       (s1_last_r),
    .code_point (s1_cp_r),
    .fields     (fields),
    .frac_ctrl  (frac_ctrl)
  );

  dtp_frac_acc u_frac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (frac_ctrl),
    .frac_nxt (frac_nxt)
  );

  // A failed parse reports every field as zero.
  always_comb begin
    res_data = '0;
    if (fields.ok) begin
      res_data[13:0]  = fields.year;
      res_data[20:14] = fields.month;
      res_data[27:21] = fields.day;
      res_data[34:28] = fields.hour;
      res_data[41:35] = fields.minute;
      res_data[48:42] = fields.second;
      res_data[80:49] = frac_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last_r) begin
      out_data_r <= res_data;
      out_ok_r   <= fields.ok;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_ok_r;

endmodule
